@@ hdl/spq_pkg.sv @@
// Shared types and codes for the stable priority queue.
package spq_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_PUSHED    = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_POPPED    = 2'd2;
    localparam logic [1:0] ST_EMPTY_POP = 2'd3;

    typedef struct packed {
        logic [1:0]  pri;
        logic [15:0] code;
        logic [15:0] handle;
    } t_entry;

    // Per-cycle command broadcast to every slot
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] pri;
    } t_slot_ctl;

endpackage

@@ hdl/spq_slot.sv @@
// One slot of the sorted store: hold, take the new entry, or shift.
module spq_slot (
    input  logic               i_clk,
    input  spq_pkg::t_slot_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_prev_ge,
    input  spq_pkg::t_entry    i_prev,
    input  spq_pkg::t_entry    i_next,
    input  spq_pkg::t_entry    i_new,
    output logic               o_ge,
    output spq_pkg::t_entry    o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Slots at or above the new level form a prefix of the store
    assign o_ge    = i_occupied && (r_entry.pri >= i_ctl.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (!o_ge) begin
                n_entry = i_prev_ge ? i_new : i_prev;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ hdl/stable_priority_queue.sv @@
// Stable bounded priority queue with sorted insertion, top level.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: a push with
//   a priority level, package code and record handle, or a pop. Output
//   channel (o_out_valid / i_out_stall) returns one result per request:
//   status, the popped entry's fields (zero unless popped) and occupancy.
//   Entries are kept sorted in a row of DEPTH slot registers, head at slot
//   0; a push lands behind every entry of equal or higher level, so each
//   level leaves in arrival order. Levels above LEVELS-1 saturate.
//   The result register holds the answer on the cycle after acceptance.
//   Throughput is one request per cycle unless a held result stalls; it is
//   set by the slot row, where each slot compares its level and shifts in
//   parallel. While the receiver stalls a held result, o_in_stall rises and
//   the queue holds; it falls again as soon as the result is taken.
//   Reset empties the queue and clears the output valid; slot contents are
//   not cleared, only the entry count.
module stable_priority_queue #(
    parameter int DEPTH  = 16,
    parameter int LEVELS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [1:0]  i_priority_req,
    input  logic [15:0] i_package_code,
    input  logic [15:0] i_record_handle,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_out_priority,
    output logic [15:0] o_out_code,
    output logic [15:0] o_out_handle,
    output logic [4:0]  o_occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic          r_out_valid;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    t_entry        r_head;
    t_entry        n_head;

    logic          accept;
    logic          full;
    logic          empty;
    logic [1:0]    pri_sat;
    t_slot_ctl     ctl;
    t_entry        new_entry;
    t_entry        slot_q  [DEPTH];
    logic          slot_ge [DEPTH];
    logic          occupied[DEPTH];
    logic [CW+4:0] count_wide;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        pri_sat = i_priority_req;
        if (32'(i_priority_req) > LEVELS - 1) begin
            pri_sat = 2'(LEVELS - 1);
        end
    end

    assign new_entry = '{pri: pri_sat, code: i_package_code, handle: i_record_handle};

    always_comb begin
        ctl.pri  = pri_sat;
        ctl.push = accept && (i_operation == OP_PUSH) && !full;
        ctl.pop  = accept && (i_operation == OP_POP) && !empty;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_slot
            assign occupied[g] = (r_count > CW'(g));
            spq_slot u_slot (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_occupied (occupied[g]),
                .i_prev_ge  ((g == 0) ? 1'b1 : slot_ge[(g == 0) ? 0 : g - 1]),
                .i_prev     ((g == 0) ? new_entry : slot_q[(g == 0) ? 0 : g - 1]),
                .i_next     ((g == DEPTH - 1) ? slot_q[g]
                                              : slot_q[(g == DEPTH - 1) ? g : g + 1]),
                .i_new      (new_entry),
                .o_ge       (slot_ge[g]),
                .o_entry    (slot_q[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        n_head   = r_head;
        if (accept) begin
            n_head = '0;
            if (i_operation == OP_PUSH) begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_PUSHED;
                    n_count  = r_count + 1'b1;
                end
            end else begin
                if (empty) begin
                    n_status = ST_EMPTY_POP;
                end else begin
                    n_status = ST_POPPED;
                    n_head   = slot_q[0];
                    n_count  = r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_head   <= n_head;
    end

    assign count_wide     = (CW + 5)'(r_count);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_head.pri;
    assign o_out_code     = r_head.code;
    assign o_out_handle   = r_head.handle;
    assign o_occupancy    = count_wide[4:0];

endmodule
